/* hw/rtl/emsd_pkg.sv */
package emsd_pkg;

    // field widths
    localparam int CMD_W      = 11;
    localparam int GAIN_W     = 7;
    localparam int PULSE_W    = 15;
    localparam int TERM_W     = 18;
    localparam int SUM_W      = 20;
    localparam int MIX_W      = 18;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // default duty resolution
    localparam int DUTY_BITS_DEF = 14;

    // register stages from command to duty
    localparam int NUM_STAGES = 8;
    // stages held by the mixer front end
    localparam int MIX_STAGES = 2;

    // servo frame length in microseconds
    localparam int PERIOD_US = 20000;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PITCH_GAIN = 3'd0,
        CFG_ROLL_GAIN  = 3'd1,
        CFG_YAW_GAIN   = 3'd2,
        CFG_MID_PULSE  = 3'd3,
        CFG_MIN_PULSE  = 3'd4,
        CFG_MAX_PULSE  = 3'd5
    } t_cfg_idx;

    // register file contents
    typedef struct packed {
        logic [GAIN_W-1:0]  pitch_gain;
        logic [GAIN_W-1:0]  roll_gain;
        logic [GAIN_W-1:0]  yaw_gain;
        logic [PULSE_W-1:0] mid_pulse;
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
    } t_cfg;

endpackage

/* hw/rtl/emsd_cfg.sv */
module emsd_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [emsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [emsd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output emsd_pkg::t_cfg                    o_cfg
);

    localparam logic [emsd_pkg::GAIN_W-1:0]  PITCH_RST = emsd_pkg::GAIN_W'(50);
    localparam logic [emsd_pkg::GAIN_W-1:0]  ROLL_RST  = emsd_pkg::GAIN_W'(70);
    localparam logic [emsd_pkg::GAIN_W-1:0]  YAW_RST   = emsd_pkg::GAIN_W'(25);
    localparam logic [emsd_pkg::PULSE_W-1:0] MID_RST   = emsd_pkg::PULSE_W'(1500);
    localparam logic [emsd_pkg::PULSE_W-1:0] MIN_RST   = emsd_pkg::PULSE_W'(500);
    localparam logic [emsd_pkg::PULSE_W-1:0] MAX_RST   = emsd_pkg::PULSE_W'(2500);

    emsd_pkg::t_cfg r_cfg;

    // writes are always accepted
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pitch_gain <= PITCH_RST;
            r_cfg.roll_gain  <= ROLL_RST;
            r_cfg.yaw_gain   <= YAW_RST;
            r_cfg.mid_pulse  <= MID_RST;
            r_cfg.min_pulse  <= MIN_RST;
            r_cfg.max_pulse  <= MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                emsd_pkg::CFG_PITCH_GAIN: begin
                    r_cfg.pitch_gain <= i_cfg_wdata[emsd_pkg::GAIN_W-1:0];
                end
                emsd_pkg::CFG_ROLL_GAIN: begin
                    r_cfg.roll_gain <= i_cfg_wdata[emsd_pkg::GAIN_W-1:0];
                end
                emsd_pkg::CFG_YAW_GAIN: begin
                    r_cfg.yaw_gain <= i_cfg_wdata[emsd_pkg::GAIN_W-1:0];
                end
                emsd_pkg::CFG_MID_PULSE: begin
                    r_cfg.mid_pulse <= i_cfg_wdata;
                end
                emsd_pkg::CFG_MIN_PULSE: begin
                    r_cfg.min_pulse <= i_cfg_wdata;
                end
                emsd_pkg::CFG_MAX_PULSE: begin
                    r_cfg.max_pulse <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

/* hw/rtl/emsd_ctl.sv */
module emsd_ctl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [emsd_pkg::NUM_STAGES-1:0]   o_en
);

    localparam int N = emsd_pkg::NUM_STAGES;

    logic [N-1:0] r_vld;
    logic [N-1:0] n_vld;
    logic [N:0]   w_rdy;

    // a stage may load when it is empty or its contents move on
    always_comb begin
        w_rdy[N] = i_out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign n_vld       = {r_vld[N-2:0], i_in_valid};
    assign o_en        = w_rdy[N-1:0];
    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_vld[N-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // input only stalls when every stage holds a beat
    a_full_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_rdy[0] |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // an accepted beat lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && w_rdy[0]) |=> r_vld[0])
        else $error("accepted beat lost at pipeline entry");

    // a bubble moving into the output stage leaves it empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rdy[N-1] && !r_vld[N-2]) |=> !r_vld[N-1])
        else $error("output stage holds a repeated beat");

endmodule

/* hw/rtl/emsd_mix.sv */
module emsd_mix (
    input  logic                                  i_clk,
    input  logic [emsd_pkg::MIX_STAGES-1:0]       i_en,
    input  emsd_pkg::t_cfg                        i_cfg,
    input  logic signed [emsd_pkg::CMD_W-1:0]     i_pitch_cmd,
    input  logic signed [emsd_pkg::CMD_W-1:0]     i_roll_cmd,
    input  logic signed [emsd_pkg::CMD_W-1:0]     i_yaw_cmd,
    output logic signed [emsd_pkg::MIX_W-1:0]     o_mix_left,
    output logic signed [emsd_pkg::MIX_W-1:0]     o_mix_right
);

    localparam int CMD_W  = emsd_pkg::CMD_W;
    localparam int TERM_W = emsd_pkg::TERM_W;
    localparam int SUM_W  = emsd_pkg::SUM_W;
    localparam int MIX_W  = emsd_pkg::MIX_W;

    localparam logic signed [CMD_W-1:0] CMD_HI = CMD_W'(1000);
    localparam logic signed [CMD_W-1:0] CMD_LO = -CMD_W'(1000);
    localparam logic signed [SUM_W-1:0] MIX_HI = SUM_W'(90000);
    localparam logic signed [SUM_W-1:0] MIX_LO = -SUM_W'(90000);

    function automatic logic signed [CMD_W-1:0] sat_cmd(input logic signed [CMD_W-1:0] x);
        logic signed [CMD_W-1:0] y;
        if (x > CMD_HI) begin
            y = CMD_HI;
        end else if (x < CMD_LO) begin
            y = CMD_LO;
        end else begin
            y = x;
        end
        return y;
    endfunction

    function automatic logic signed [SUM_W-1:0] clamp_mix(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] y;
        if (x > MIX_HI) begin
            y = MIX_HI;
        end else if (x < MIX_LO) begin
            y = MIX_LO;
        end else begin
            y = x;
        end
        return y;
    endfunction

    logic signed [CMD_W-1:0]  w_p_sat;
    logic signed [CMD_W-1:0]  w_r_sat;
    logic signed [CMD_W-1:0]  w_y_sat;
    logic signed [TERM_W-1:0] n_p_term;
    logic signed [TERM_W-1:0] n_r_term;
    logic signed [TERM_W-1:0] n_y_term;
    logic signed [TERM_W-1:0] r_p_term;
    logic signed [TERM_W-1:0] r_r_term;
    logic signed [TERM_W-1:0] r_y_term;
    logic signed [SUM_W-1:0]  w_sum_left;
    logic signed [SUM_W-1:0]  w_sum_right;
    logic signed [MIX_W-1:0]  n_mix_left;
    logic signed [MIX_W-1:0]  n_mix_right;
    logic signed [MIX_W-1:0]  r_mix_left;
    logic signed [MIX_W-1:0]  r_mix_right;

    // stage 1: saturate commands and scale by gains
    assign w_p_sat  = sat_cmd(i_pitch_cmd);
    assign w_r_sat  = sat_cmd(i_roll_cmd);
    assign w_y_sat  = sat_cmd(i_yaw_cmd);
    assign n_p_term = TERM_W'(w_p_sat) * TERM_W'($signed({1'b0, i_cfg.pitch_gain}));
    assign n_r_term = TERM_W'(w_r_sat) * TERM_W'($signed({1'b0, i_cfg.roll_gain}));
    assign n_y_term = TERM_W'(w_y_sat) * TERM_W'($signed({1'b0, i_cfg.yaw_gain}));

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p_term <= n_p_term;
            r_r_term <= n_r_term;
            r_y_term <= n_y_term;
        end
    end

    // stage 2: elevon sums in millidegrees, clamped to +-90 degrees
    assign w_sum_left  = SUM_W'(r_p_term) - SUM_W'(r_r_term) + SUM_W'(r_y_term);
    assign w_sum_right = SUM_W'(r_p_term) + SUM_W'(r_r_term) + SUM_W'(r_y_term);
    assign n_mix_left  = MIX_W'(clamp_mix(w_sum_left));
    assign n_mix_right = MIX_W'(clamp_mix(w_sum_right));

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_mix_left  <= n_mix_left;
            r_mix_right <= n_mix_right;
        end
    end

    assign o_mix_left  = r_mix_left;
    assign o_mix_right = r_mix_right;

endmodule

/* hw/rtl/emsd_lane.sv */
module emsd_lane #(
    parameter int DUTY_BITS = emsd_pkg::DUTY_BITS_DEF
) (
    input  logic                                                  i_clk,
    input  logic [emsd_pkg::NUM_STAGES-emsd_pkg::MIX_STAGES-1:0] i_en,
    input  emsd_pkg::t_cfg                                        i_cfg,
    input  logic signed [emsd_pkg::MIX_W-1:0]                     i_mix,
    output logic [DUTY_BITS-1:0]                                  o_duty
);

    localparam int MIX_W   = emsd_pkg::MIX_W;
    localparam int PULSE_W = emsd_pkg::PULSE_W;

    // |mix| / 1000 by reciprocal, exact for |mix| <= 90000
    localparam int MAG_W      = MIX_W - 1;
    localparam int ANG_W      = 7;
    localparam int ANG_SHIFT  = 27;
    localparam int ANG_RECIP  = 134218;
    localparam int ANG_PROD_W = ANG_SHIFT + 8;

    // angle * 1000 / 90 by reciprocal, exact for angle <= 90
    localparam int OFF_W      = 10;
    localparam int OFF_SHIFT  = 16;
    localparam int OFF_RECIP  = 728200;
    localparam int OFF_PROD_W = OFF_SHIFT + 11;

    localparam int PSUM_W     = PULSE_W + 2;

    // x / 20000 = (x >> 5) / 625, estimated from the upper bits then corrected
    localparam int X_W        = PULSE_W + DUTY_BITS;
    localparam int DIV_SHIFT  = 5;
    localparam int Y_W        = X_W - DIV_SHIFT;
    localparam int Z_SHIFT    = 10;
    localparam int Q_SHIFT    = 16;
    localparam int Q_RECIP    = 107374;
    localparam int Q_PROD_W   = DUTY_BITS + Q_SHIFT + 1;
    localparam int DIV_REM    = 625;

    localparam logic [DUTY_BITS-1:0] DUTY_MAX = {DUTY_BITS{1'b1}};

    logic                        w_neg;
    logic [MAG_W-1:0]            w_mag;
    logic [ANG_PROD_W-1:0]       w_ang_prod;
    logic [ANG_W-1:0]            n_ang;
    logic                        r_neg3;
    logic [ANG_W-1:0]            r_ang;

    logic [OFF_PROD_W-1:0]       w_off_prod;
    logic [OFF_W-1:0]            n_off;
    logic                        r_neg4;
    logic [OFF_W-1:0]            r_off;

    logic signed [PSUM_W-1:0]    w_base;
    logic signed [PSUM_W-1:0]    w_offs;
    logic signed [PSUM_W-1:0]    w_raw;
    logic signed [PSUM_W-1:0]    w_lo;
    logic signed [PSUM_W-1:0]    w_hi;
    logic signed [PSUM_W-1:0]    w_lo_clamped;
    logic signed [PSUM_W-1:0]    w_hi_clamped;
    logic [PULSE_W-1:0]          n_pulse;
    logic [PULSE_W-1:0]          r_pulse;

    logic [X_W-1:0]              n_x;
    logic                        n_sat6;
    logic [X_W-1:0]              r_x;
    logic                        r_sat6;

    logic [Y_W-1:0]              n_y;
    logic [DUTY_BITS-1:0]        w_z;
    logic [Q_PROD_W-1:0]         w_q_prod;
    logic [DUTY_BITS-1:0]        n_q0;
    logic [Y_W-1:0]              r_y;
    logic [DUTY_BITS-1:0]        r_q0;
    logic                        r_sat7;

    logic [Y_W-1:0]              w_qm;
    logic [Y_W-1:0]              w_rem;
    logic [1:0]                  w_fix;
    logic [DUTY_BITS-1:0]        n_duty;
    logic [DUTY_BITS-1:0]        r_duty;

    // stage 3: whole degrees, truncated toward zero
    assign w_neg      = i_mix[MIX_W-1];
    assign w_mag      = w_neg ? MAG_W'(-i_mix) : MAG_W'(i_mix);
    assign w_ang_prod = ANG_PROD_W'(w_mag) * ANG_PROD_W'(ANG_RECIP);
    assign n_ang      = w_ang_prod[ANG_SHIFT +: ANG_W];

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_neg3 <= w_neg;
            r_ang  <= n_ang;
        end
    end

    // stage 4: pulse offset magnitude in microseconds
    assign w_off_prod = OFF_PROD_W'(r_ang) * OFF_PROD_W'(OFF_RECIP);
    assign n_off      = w_off_prod[OFF_SHIFT +: OFF_W];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_neg4 <= r_neg3;
            r_off  <= n_off;
        end
    end

    // stage 5: pulse around neutral, min clamp then max clamp
    assign w_base       = $signed({2'b00, i_cfg.mid_pulse});
    assign w_offs       = $signed(PSUM_W'(r_off));
    assign w_raw        = r_neg4 ? (w_base - w_offs) : (w_base + w_offs);
    assign w_lo         = $signed({2'b00, i_cfg.min_pulse});
    assign w_hi         = $signed({2'b00, i_cfg.max_pulse});
    assign w_lo_clamped = (w_raw < w_lo) ? w_lo : w_raw;
    assign w_hi_clamped = (w_lo_clamped > w_hi) ? w_hi : w_lo_clamped;
    assign n_pulse      = PULSE_W'(w_hi_clamped);

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_pulse <= n_pulse;
        end
    end

    // stage 6: scale pulse to duty counts, flag full-frame pulses
    assign n_x    = X_W'(r_pulse) * X_W'(DUTY_MAX);
    assign n_sat6 = (r_pulse >= PULSE_W'(emsd_pkg::PERIOD_US));

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_x    <= n_x;
            r_sat6 <= n_sat6;
        end
    end

    // stage 7: quotient estimate, at most three below the true value
    assign n_y      = r_x[X_W-1:DIV_SHIFT];
    assign w_z      = n_y[Y_W-1:Z_SHIFT];
    assign w_q_prod = Q_PROD_W'(w_z) * Q_PROD_W'(Q_RECIP);
    assign n_q0     = w_q_prod[Q_SHIFT +: DUTY_BITS];

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_y    <= n_y;
            r_q0   <= n_q0;
            r_sat7 <= r_sat6;
        end
    end

    // stage 8: remainder correction and saturation
    assign w_qm   = Y_W'(r_q0) * Y_W'(DIV_REM);
    assign w_rem  = r_y - w_qm;
    assign w_fix  = {1'b0, (w_rem >= Y_W'(DIV_REM))}
                  + {1'b0, (w_rem >= Y_W'(2 * DIV_REM))}
                  + {1'b0, (w_rem >= Y_W'(3 * DIV_REM))};
    assign n_duty = r_sat7 ? DUTY_MAX : (r_q0 + DUTY_BITS'(w_fix));

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_duty <= n_duty;
        end
    end

    assign o_duty = r_duty;

endmodule

/* hw/rtl/elevon_mixer_servo_duty.sv */
// Flying-wing elevon mixer: pitch, roll and yaw commands (saturated to +-1000)
// are mixed with the gain registers into left and right deflections, clamped to
// +-90 degrees, turned into servo pulse widths around mid_pulse, limited to
// min_pulse..max_pulse and scaled to DUTY_BITS-wide duty words of a 20 ms frame.
// Inner servos repeat the outer duty of their side. The datapath is an
// eight-stage pipeline, one register per multiply or add/compare step, so a
// command beat enters every cycle unless every stage holds a beat and the
// output is stalled; a stalled output holds its beat while earlier stages keep
// filling. Configuration writes are always accepted and should only be made
// while no command beat is in flight.
module elevon_mixer_servo_duty #(
    parameter int DUTY_BITS = emsd_pkg::DUTY_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [emsd_pkg::CMD_W-1:0]     i_pitch_cmd,
    input  logic signed [emsd_pkg::CMD_W-1:0]     i_roll_cmd,
    input  logic signed [emsd_pkg::CMD_W-1:0]     i_yaw_cmd,

    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [DUTY_BITS-1:0]                  o_left_outer_duty,
    output logic [DUTY_BITS-1:0]                  o_left_inner_duty,
    output logic [DUTY_BITS-1:0]                  o_right_inner_duty,
    output logic [DUTY_BITS-1:0]                  o_right_outer_duty,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [emsd_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [emsd_pkg::CFG_DATA_W-1:0]       i_cfg_wdata
);

    localparam int N  = emsd_pkg::NUM_STAGES;
    localparam int NM = emsd_pkg::MIX_STAGES;

    emsd_pkg::t_cfg                        w_cfg;
    logic [N-1:0]                          w_en;
    logic signed [emsd_pkg::MIX_W-1:0]     w_mix_left;
    logic signed [emsd_pkg::MIX_W-1:0]     w_mix_right;
    logic [DUTY_BITS-1:0]                  w_duty_left;
    logic [DUTY_BITS-1:0]                  w_duty_right;

    // configuration registers
    emsd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // stage valids and load enables
    emsd_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .o_en        (w_en)
    );

    // command mixing
    emsd_mix u_mix (
        .i_clk       (i_clk),
        .i_en        (w_en[NM-1:0]),
        .i_cfg       (w_cfg),
        .i_pitch_cmd (i_pitch_cmd),
        .i_roll_cmd  (i_roll_cmd),
        .i_yaw_cmd   (i_yaw_cmd),
        .o_mix_left  (w_mix_left),
        .o_mix_right (w_mix_right)
    );

    // per-side angle to duty
    emsd_lane #(
        .DUTY_BITS (DUTY_BITS)
    ) u_lane_left (
        .i_clk  (i_clk),
        .i_en   (w_en[N-1:NM]),
        .i_cfg  (w_cfg),
        .i_mix  (w_mix_left),
        .o_duty (w_duty_left)
    );

    emsd_lane #(
        .DUTY_BITS (DUTY_BITS)
    ) u_lane_right (
        .i_clk  (i_clk),
        .i_en   (w_en[N-1:NM]),
        .i_cfg  (w_cfg),
        .i_mix  (w_mix_right),
        .o_duty (w_duty_right)
    );

    // inner servos follow the outer ones
    assign o_left_outer_duty  = w_duty_left;
    assign o_left_inner_duty  = w_duty_left;
    assign o_right_inner_duty = w_duty_right;
    assign o_right_outer_duty = w_duty_right;

endmodule
